// ----- sv/efaa_pkg.sv -----
package efaa_pkg;

    localparam int NODES_DEFAULT     = 1024;
    localparam int FRAC_BITS_DEFAULT = 16;

    localparam logic [1:0] OP_LOAD_STATE = 2'd0;
    localparam logic [1:0] OP_LOAD_DISS  = 2'd1;
    localparam logic [1:0] OP_EDGE       = 2'd2;
    localparam logic [1:0] OP_READ       = 2'd3;

    // Operand pairs of the shared multiplier.
    localparam logic [3:0] MUL_NONE    = 4'd0;
    localparam logic [3:0] MUL_MX_FX   = 4'd1;
    localparam logic [3:0] MUL_MY_FY   = 4'd2;
    localparam logic [3:0] MUL_FX_PAV  = 4'd3;
    localparam logic [3:0] MUL_FY_PAV  = 4'd4;
    localparam logic [3:0] MUL_QA_RHOA = 4'd5;
    localparam logic [3:0] MUL_QB_RHOB = 4'd6;
    localparam logic [3:0] MUL_QA_MXA  = 4'd7;
    localparam logic [3:0] MUL_QB_MXB  = 4'd8;
    localparam logic [3:0] MUL_QA_MYA  = 4'd9;
    localparam logic [3:0] MUL_QB_MYB  = 4'd10;
    localparam logic [3:0] MUL_QA_RHA  = 4'd11;
    localparam logic [3:0] MUL_QB_RHB  = 4'd12;

    typedef struct packed {
        logic       cap_in;
        logic       side;
        logic       st_wr;
        logic       st_rd;
        logic       cap_a;
        logic       cap_b;
        logic [3:0] mul_sel;
        logic       acc_load;
        logic       acc_add;
        logic       div_start;
        logic       qs_wr;
        logic       ext_x_wr;
        logic       ext_y_wr;
        logic       flux_wr;
        logic [1:0] flux_k;
        logic       res_rd;
        logic       res_wr;
        logic       dis_wr;
        logic       out_wr;
    } efaa_cmd_t;

    typedef struct packed {
        logic [1:0] in_op;
        logic       in_a_ok;
        logic       in_b_ok;
        logic       div_busy;
        logic       div_done;
    } efaa_status_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647)
            r = 32'sh7fffffff;
        else if (v < -64'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

// ----- sv/efaa_div.sv -----
module efaa_div
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [63:0] num,
    input  logic signed [31:0] den,
    output logic               busy,
    output logic               done,
    output logic signed [31:0] quot
);

    localparam int NB = 64;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [6:0]        cnt_reg, cnt_next;
    logic [63:0]       quo_reg, quo_next;
    logic [31:0]       rem_reg, rem_next;
    logic [31:0]       dm_reg, dm_next;
    logic              nneg_reg, nneg_next;
    logic              neg_reg, neg_next;
    logic              dz_reg, dz_next;
    logic              nz_reg, nz_next;
    logic [32:0]       shifted;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dm_next   = dm_reg;
        nneg_next = nneg_reg;
        neg_next  = neg_reg;
        dz_next   = dz_reg;
        nz_next   = nz_reg;
        shifted   = {rem_reg, quo_reg[63]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = 7'(NB);
            quo_next  = num[63] ? (64'd0 - 64'(num)) : 64'(num);
            rem_next  = '0;
            dm_next   = den[31] ? (32'd0 - 32'(den)) : 32'(den);
            nneg_next = num[63];
            neg_next  = num[63] ^ den[31];
            dz_next   = (den == 32'sd0);
            nz_next   = (num != 64'sd0);
        end
        else if (busy_reg)
        begin
            // One quotient bit per cycle, restoring form.
            if (shifted >= {1'b0, dm_reg})
            begin
                rem_next = 32'(shifted - {1'b0, dm_reg});
                quo_next = {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[31:0];
                quo_next = {quo_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        dm_reg   <= dm_next;
        nneg_reg <= nneg_next;
        neg_reg  <= neg_next;
        dz_reg   <= dz_next;
        nz_reg   <= nz_next;
    end

    always_comb
    begin
        if (dz_reg)
            quot = nneg_reg ? 32'sh80000000 : (nz_reg ? 32'sh7fffffff : 32'sd0);
        else if (neg_reg)
            quot = (quo_reg > 64'd2147483648) ? 32'sh80000000
                                              : (32'd0 - quo_reg[31:0]);
        else
            quot = (quo_reg > 64'd2147483647) ? 32'sh7fffffff : quo_reg[31:0];
    end

    assign busy = busy_reg;
    assign done = done_reg;

endmodule

// ----- sv/efaa_dp.sv -----
module efaa_dp
#(
    parameter int NODES     = efaa_pkg::NODES_DEFAULT,
    parameter int FRAC_BITS = efaa_pkg::FRAC_BITS_DEFAULT
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  efaa_pkg::efaa_cmd_t     cmd,
    output efaa_pkg::efaa_status_t  status,
    input  logic [1:0]              op,
    input  logic [9:0]              node_a,
    input  logic [9:0]              node_b,
    input  logic signed [31:0]      value_dens,
    input  logic signed [31:0]      value_xmom,
    input  logic signed [31:0]      value_ymom,
    input  logic signed [31:0]      value_ener,
    input  logic signed [31:0]      pressure,
    input  logic signed [31:0]      face_x,
    input  logic signed [31:0]      face_y,
    output logic                    done,
    output logic [9:0]              node,
    output logic signed [31:0]      res_dens,
    output logic signed [31:0]      res_xmom,
    output logic signed [31:0]      res_ymom,
    output logic signed [31:0]      res_ener
);

    localparam int AW = (NODES > 1) ? $clog2(NODES) : 1;

    logic [9:0]         na_reg, nb_reg;
    logic               a_ok_reg;
    logic signed [31:0] v_reg [4];
    logic signed [31:0] pr_in_reg, fx_reg, fy_reg;

    logic [159:0]       st_mem [NODES];
    logic [159:0]       st_rd_reg;
    logic [127:0]       res_mem [NODES];
    logic [127:0]       res_rd_reg;

    logic signed [31:0] rho_reg [2];
    logic signed [31:0] mx_reg [2];
    logic signed [31:0] my_reg [2];
    logic signed [31:0] en_reg [2];
    logic signed [31:0] p_reg [2];
    logic signed [31:0] qs_reg [2];
    logic signed [31:0] rh [2];
    logic signed [31:0] f_reg [4];

    logic signed [31:0] mul_x, mul_y;
    logic signed [63:0] prod_reg, acc_reg, ext_x_reg, ext_y_reg;
    logic signed [64:0] acc_sum;
    logic signed [63:0] acc_sat;
    logic signed [32:0] p_sum;
    logic signed [31:0] pav;
    logic signed [63:0] flux_t;

    logic [AW-1:0]      addr_a, addr_b, addr_s;
    logic               div_busy, div_done;
    logic signed [31:0] div_q;
    logic [127:0]       res_upd, res_dis;

    logic               done_reg;
    logic [9:0]         node_reg;
    logic signed [31:0] out_reg [4];

    assign addr_a = AW'(na_reg);
    assign addr_b = AW'(nb_reg);
    assign addr_s = cmd.side ? addr_b : addr_a;

    assign status.in_op    = op;
    assign status.in_a_ok  = (32'(node_a) < NODES);
    assign status.in_b_ok  = (32'(node_b) < NODES);
    assign status.div_busy = div_busy;
    assign status.div_done = div_done;

    always_ff @(posedge clk)
    begin
        if (cmd.cap_in)
        begin
            na_reg    <= node_a;
            nb_reg    <= node_b;
            a_ok_reg  <= (32'(node_a) < NODES);
            v_reg[0]  <= value_dens;
            v_reg[1]  <= value_xmom;
            v_reg[2]  <= value_ymom;
            v_reg[3]  <= value_ener;
            pr_in_reg <= pressure;
            fx_reg    <= face_x;
            fy_reg    <= face_y;
        end
    end

    // Node state memory: {p, E, my, mx, rho}.
    always_ff @(posedge clk)
    begin
        if (cmd.st_wr)
            st_mem[addr_a] <= {pr_in_reg, v_reg[3], v_reg[2], v_reg[1], v_reg[0]};
        if (cmd.st_rd)
            st_rd_reg <= st_mem[addr_s];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cap_a || cmd.cap_b)
        begin
            rho_reg[cmd.cap_b] <= st_rd_reg[31:0];
            mx_reg[cmd.cap_b]  <= st_rd_reg[63:32];
            my_reg[cmd.cap_b]  <= st_rd_reg[95:64];
            en_reg[cmd.cap_b]  <= st_rd_reg[127:96];
            p_reg[cmd.cap_b]   <= st_rd_reg[159:128];
        end
    end

    assign rh[0] = efaa_pkg::sat32(64'(p_reg[0]) + 64'(en_reg[0]));
    assign rh[1] = efaa_pkg::sat32(64'(p_reg[1]) + 64'(en_reg[1]));
    assign p_sum = 33'(p_reg[0]) + 33'(p_reg[1]);
    assign pav   = p_sum[32:1];

    always_comb
    begin
        mul_x = '0;
        mul_y = '0;
        case (cmd.mul_sel)
            efaa_pkg::MUL_MX_FX:   begin mul_x = mx_reg[cmd.side]; mul_y = fx_reg; end
            efaa_pkg::MUL_MY_FY:   begin mul_x = my_reg[cmd.side]; mul_y = fy_reg; end
            efaa_pkg::MUL_FX_PAV:  begin mul_x = fx_reg;    mul_y = pav;        end
            efaa_pkg::MUL_FY_PAV:  begin mul_x = fy_reg;    mul_y = pav;        end
            efaa_pkg::MUL_QA_RHOA: begin mul_x = qs_reg[0]; mul_y = rho_reg[0]; end
            efaa_pkg::MUL_QB_RHOB: begin mul_x = qs_reg[1]; mul_y = rho_reg[1]; end
            efaa_pkg::MUL_QA_MXA:  begin mul_x = qs_reg[0]; mul_y = mx_reg[0];  end
            efaa_pkg::MUL_QB_MXB:  begin mul_x = qs_reg[1]; mul_y = mx_reg[1];  end
            efaa_pkg::MUL_QA_MYA:  begin mul_x = qs_reg[0]; mul_y = my_reg[0];  end
            efaa_pkg::MUL_QB_MYB:  begin mul_x = qs_reg[1]; mul_y = my_reg[1];  end
            efaa_pkg::MUL_QA_RHA:  begin mul_x = qs_reg[0]; mul_y = rh[0];      end
            efaa_pkg::MUL_QB_RHB:  begin mul_x = qs_reg[1]; mul_y = rh[1];      end
            default:               begin mul_x = '0;        mul_y = '0;         end
        endcase
    end

    // Saturating 64-bit accumulate of the registered product.
    assign acc_sum = 65'(acc_reg) + 65'(prod_reg);
    always_comb
    begin
        if (acc_sum[64] != acc_sum[63])
            acc_sat = acc_sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        else
            acc_sat = acc_sum[63:0];
    end

    always_comb
    begin
        flux_t = acc_reg >>> (FRAC_BITS + 1);
        if (cmd.flux_k == 2'd1)
            flux_t = flux_t + ext_x_reg;
        else if (cmd.flux_k == 2'd2)
            flux_t = flux_t + ext_y_reg;
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_x * mul_y;
        if (cmd.acc_load)
            acc_reg <= prod_reg;
        else if (cmd.acc_add)
            acc_reg <= acc_sat;
        if (cmd.ext_x_wr)
            ext_x_reg <= prod_reg >>> FRAC_BITS;
        if (cmd.ext_y_wr)
            ext_y_reg <= prod_reg >>> FRAC_BITS;
        if (cmd.qs_wr)
            qs_reg[cmd.side] <= div_q;
        if (cmd.flux_wr)
            f_reg[cmd.flux_k] <= efaa_pkg::sat32(flux_t);
    end

    efaa_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (acc_reg),
        .den   (rho_reg[cmd.side]),
        .busy  (div_busy),
        .done  (div_done),
        .quot  (div_q)
    );

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            if (cmd.side)
                res_upd[32*k +: 32] = efaa_pkg::sat32(64'($signed(res_rd_reg[32*k +: 32]))
                                                      - 64'(f_reg[k]));
            else
                res_upd[32*k +: 32] = efaa_pkg::sat32(64'($signed(res_rd_reg[32*k +: 32]))
                                                      + 64'(f_reg[k]));
            res_dis[32*k +: 32] = efaa_pkg::sat32(64'sd0 - 64'(v_reg[k]));
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.dis_wr)
            res_mem[addr_a] <= res_dis;
        else if (cmd.res_wr)
            res_mem[addr_s] <= res_upd;
        if (cmd.res_rd)
            res_rd_reg <= res_mem[addr_s];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= cmd.out_wr;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_wr)
        begin
            node_reg <= na_reg;
            for (int k = 0; k < 4; k++)
                out_reg[k] <= a_ok_reg ? res_rd_reg[32*k +: 32] : 32'sd0;
        end
    end

    assign done     = done_reg;
    assign node     = node_reg;
    assign res_dens = out_reg[0];
    assign res_xmom = out_reg[1];
    assign res_ymom = out_reg[2];
    assign res_ener = out_reg[3];

endmodule

// ----- sv/efaa_ctrl.sv -----
module efaa_ctrl
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  efaa_pkg::efaa_status_t  status,
    output efaa_pkg::efaa_cmd_t     cmd
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_ST_WR    = 4'd1;
    localparam logic [3:0] S_DIS_WR   = 4'd2;
    localparam logic [3:0] S_RD_RD    = 4'd3;
    localparam logic [3:0] S_RD_OUT   = 4'd4;
    localparam logic [3:0] S_RD_A     = 4'd5;
    localparam logic [3:0] S_RD_B     = 4'd6;
    localparam logic [3:0] S_CAP_B    = 4'd7;
    localparam logic [3:0] S_NUM      = 4'd8;
    localparam logic [3:0] S_DIV_GO   = 4'd9;
    localparam logic [3:0] S_DIV_WAIT = 4'd10;
    localparam logic [3:0] S_FLUX     = 4'd11;
    localparam logic [3:0] S_RES_RD   = 4'd12;
    localparam logic [3:0] S_RES_WR   = 4'd13;

    logic [3:0] state_reg, state_next;
    logic [3:0] step_reg, step_next;
    logic       side_reg, side_next;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        side_next  = side_reg;
        cmd        = '0;
        cmd.side   = side_reg;
        case (state_reg)
            S_IDLE:
            begin
                cmd.cap_in = start;
                side_next  = 1'b0;
                step_next  = '0;
                if (start)
                begin
                    case (status.in_op)
                        efaa_pkg::OP_LOAD_STATE:
                            if (status.in_a_ok) state_next = S_ST_WR;
                        efaa_pkg::OP_LOAD_DISS:
                            if (status.in_a_ok) state_next = S_DIS_WR;
                        efaa_pkg::OP_EDGE:
                            if (status.in_a_ok && status.in_b_ok) state_next = S_RD_A;
                        default:
                            state_next = S_RD_RD;
                    endcase
                end
            end
            S_ST_WR:
            begin
                cmd.st_wr  = 1'b1;
                state_next = S_IDLE;
            end
            S_DIS_WR:
            begin
                cmd.dis_wr = 1'b1;
                state_next = S_IDLE;
            end
            S_RD_RD:
            begin
                cmd.res_rd = 1'b1;
                state_next = S_RD_OUT;
            end
            S_RD_OUT:
            begin
                cmd.out_wr = 1'b1;
                state_next = S_IDLE;
            end
            S_RD_A:
            begin
                cmd.st_rd  = 1'b1;
                state_next = S_RD_B;
            end
            S_RD_B:
            begin
                cmd.cap_a  = 1'b1;
                cmd.st_rd  = 1'b1;
                cmd.side   = 1'b1;
                state_next = S_CAP_B;
            end
            S_CAP_B:
            begin
                cmd.cap_b  = 1'b1;
                state_next = S_NUM;
            end
            S_NUM:
            begin
                // Momentum dotted with the face vector, one product per cycle.
                step_next = step_reg + 4'd1;
                case (step_reg)
                    4'd0: cmd.mul_sel = efaa_pkg::MUL_MX_FX;
                    4'd1:
                    begin
                        cmd.mul_sel  = efaa_pkg::MUL_MY_FY;
                        cmd.acc_load = 1'b1;
                    end
                    default:
                    begin
                        cmd.acc_add = 1'b1;
                        step_next   = '0;
                        state_next  = S_DIV_GO;
                    end
                endcase
            end
            S_DIV_GO:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd.qs_wr = 1'b1;
                    if (side_reg)
                    begin
                        side_next  = 1'b0;
                        state_next = S_FLUX;
                    end
                    else
                    begin
                        side_next  = 1'b1;
                        state_next = S_NUM;
                    end
                end
            end
            S_FLUX:
            begin
                step_next = step_reg + 4'd1;
                case (step_reg)
                    4'd0: cmd.mul_sel = efaa_pkg::MUL_FX_PAV;
                    4'd1:
                    begin
                        cmd.mul_sel  = efaa_pkg::MUL_QA_RHOA;
                        cmd.ext_x_wr = 1'b1;
                    end
                    4'd2:
                    begin
                        cmd.mul_sel  = efaa_pkg::MUL_QB_RHOB;
                        cmd.acc_load = 1'b1;
                    end
                    4'd3:
                    begin
                        cmd.mul_sel = efaa_pkg::MUL_FY_PAV;
                        cmd.acc_add = 1'b1;
                    end
                    4'd4:
                    begin
                        cmd.flux_wr  = 1'b1;
                        cmd.flux_k   = 2'd0;
                        cmd.ext_y_wr = 1'b1;
                        cmd.mul_sel  = efaa_pkg::MUL_QA_MXA;
                    end
                    4'd5:
                    begin
                        cmd.mul_sel  = efaa_pkg::MUL_QB_MXB;
                        cmd.acc_load = 1'b1;
                    end
                    4'd6: cmd.acc_add = 1'b1;
                    4'd7:
                    begin
                        cmd.flux_wr = 1'b1;
                        cmd.flux_k  = 2'd1;
                        cmd.mul_sel = efaa_pkg::MUL_QA_MYA;
                    end
                    4'd8:
                    begin
                        cmd.mul_sel  = efaa_pkg::MUL_QB_MYB;
                        cmd.acc_load = 1'b1;
                    end
                    4'd9: cmd.acc_add = 1'b1;
                    4'd10:
                    begin
                        cmd.flux_wr = 1'b1;
                        cmd.flux_k  = 2'd2;
                        cmd.mul_sel = efaa_pkg::MUL_QA_RHA;
                    end
                    4'd11:
                    begin
                        cmd.mul_sel  = efaa_pkg::MUL_QB_RHB;
                        cmd.acc_load = 1'b1;
                    end
                    4'd12: cmd.acc_add = 1'b1;
                    default:
                    begin
                        cmd.flux_wr = 1'b1;
                        cmd.flux_k  = 2'd3;
                        step_next   = '0;
                        side_next   = 1'b0;
                        state_next  = S_RES_RD;
                    end
                endcase
            end
            S_RES_RD:
            begin
                // Node i is updated and written back before node j is read.
                cmd.res_rd = 1'b1;
                state_next = S_RES_WR;
            end
            S_RES_WR:
            begin
                cmd.res_wr = 1'b1;
                if (side_reg)
                    state_next = S_IDLE;
                else
                begin
                    side_next  = 1'b1;
                    state_next = S_RES_RD;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
            side_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            side_reg  <= side_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> !status.div_busy)
        else $error("divider started while busy");

    a_qs_after_div: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.qs_wr |-> status.div_done)
        else $error("normal velocity written without a finished division");

    a_res_rmw: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.res_wr |-> $past(cmd.res_rd) && $past(cmd.side) == cmd.side)
        else $error("residual write not preceded by its read");

    a_flux_after_acc: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.flux_wr |-> $past(cmd.acc_add))
        else $error("flux written before accumulation finished");

endmodule

// ----- sv/edge_flux_average_accumulate.sv -----
// Edge-based central flux accumulator for 2D Euler. A transaction is taken when
// start is high and busy is low; busy stays high until the block can take the
// next one. The result of a residual read appears on the result ports for
// exactly one cycle with done high, in the first cycle in which busy is low
// again; the receiver cannot stall it and must take it then. A load or an edge
// that names a node out of range is dropped. The time an edge takes is set by
// the bit-serial divider that forms each of the two normal velocities, plus one
// shared multiplier and single-port node and residual memories.
// Node memories are not cleared by reset; read only entries that were loaded.
module edge_flux_average_accumulate
#(
    parameter int NODES     = efaa_pkg::NODES_DEFAULT,
    parameter int FRAC_BITS = efaa_pkg::FRAC_BITS_DEFAULT
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         op,
    input  logic [9:0]         node_a,
    input  logic [9:0]         node_b,
    input  logic signed [31:0] value_dens,
    input  logic signed [31:0] value_xmom,
    input  logic signed [31:0] value_ymom,
    input  logic signed [31:0] value_ener,
    input  logic signed [31:0] pressure,
    input  logic signed [31:0] face_x,
    input  logic signed [31:0] face_y,
    output logic               done,
    output logic [9:0]         node,
    output logic signed [31:0] res_dens,
    output logic signed [31:0] res_xmom,
    output logic signed [31:0] res_ymom,
    output logic signed [31:0] res_ener
);

    efaa_pkg::efaa_cmd_t    cmd;
    efaa_pkg::efaa_status_t status;

    efaa_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .status (status),
        .cmd    (cmd)
    );

    efaa_dp
    #(
        .NODES     (NODES),
        .FRAC_BITS (FRAC_BITS)
    )
    u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .op         (op),
        .node_a     (node_a),
        .node_b     (node_b),
        .value_dens (value_dens),
        .value_xmom (value_xmom),
        .value_ymom (value_ymom),
        .value_ener (value_ener),
        .pressure   (pressure),
        .face_x     (face_x),
        .face_y     (face_y),
        .done       (done),
        .node       (node),
        .res_dens   (res_dens),
        .res_xmom   (res_xmom),
        .res_ymom   (res_ymom),
        .res_ener   (res_ener)
    );

endmodule
